@@ design/tbhrc_pkg.sv @@
// Package for the two-button hold-to-repeat counter unit.
// Holds the mode and phase codes, register indexes, counter types and reset values.
// Has no dependencies; the top level and its checker use it by scoped names.
package tbhrc_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned THR_W  = 10;
  localparam int unsigned IV_W   = 8;
  localparam int unsigned VAL_W  = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_W  = 10;

  typedef logic [CNT_W-1:0] cnt_t;

  // Hold counter and the two repeat-interval counters of one button.
  typedef struct packed {
    cnt_t hold;
    cnt_t slow;
    cnt_t fast;
  } cnt_set_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_UP_FIRST = 3'd1,
    MODE_UP_SLOW  = 3'd2,
    MODE_UP_FAST  = 3'd3,
    MODE_DN_FIRST = 3'd4,
    MODE_DN_SLOW  = 3'd5,
    MODE_DN_FAST  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_SLOW  = 2'd1,
    PH_FAST  = 2'd2
  } phase_e;

  localparam logic [IDX_W-1:0] REG_HOLD_THR_SLOW = 4'd0;
  localparam logic [IDX_W-1:0] REG_HOLD_THR_FAST = 4'd1;
  localparam logic [IDX_W-1:0] REG_SLOW_IV       = 4'd2;
  localparam logic [IDX_W-1:0] REG_FAST_IV       = 4'd3;

  localparam logic [THR_W-1:0] HOLD_THR_SLOW_RST = 10'd100;
  localparam logic [THR_W-1:0] HOLD_THR_FAST_RST = 10'd300;
  localparam logic [IV_W-1:0]  SLOW_IV_RST       = 8'd50;
  localparam logic [IV_W-1:0]  FAST_IV_RST       = 8'd10;

  // Saturating increment of a 16-bit counter.
  function automatic cnt_t sat_inc(cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

endpackage

@@ design/two_button_hold_repeat_counter_unit.sv @@
// Top level of the two-button hold-to-repeat counter unit.
// Depends on tbhrc_pkg for codes, types and reset values.
// Its ports are checked by tbhrc_checker, which is bound to it.

// Each input transaction is one tick: the raw active-low levels of the up and
// down buttons. The unit presents the result (the 8-bit counter value and the
// repeat mode) in the cycle after the transaction is accepted. The counter and
// mode state registers are also the result register, so a new tick is accepted
// in the same cycle in which the waiting result is taken, and the sustained rate
// is one tick per cycle while out_ready_i stays high. The four configuration
// registers (slow and fast hold thresholds, slow and fast repeat intervals) are
// written through the plain write port; the user must write them only while
// the unit is idle, as the block itself does not enforce it. A write to an
// index beyond the fourth register is ignored.
module two_button_hold_repeat_counter_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tbhrc_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [tbhrc_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               up_level_i,
  input  logic                               down_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tbhrc_pkg::VAL_W-1:0]        display_value_o,
  output logic [tbhrc_pkg::MODE_W-1:0]       mode_o
);

  // Configuration registers.
  logic [tbhrc_pkg::THR_W-1:0] thr_slow_q, thr_fast_q;
  logic [tbhrc_pkg::IV_W-1:0]  slow_iv_q, fast_iv_q;

  // Tick state. Only the last sample of each button is kept: the earlier
  // sample is always the one that the next tick compares against.
  logic                        up_last_q, dn_last_q;
  tbhrc_pkg::cnt_set_t         up_cnt_q, up_cnt_d, dn_cnt_q, dn_cnt_d;
  logic [tbhrc_pkg::VAL_W-1:0] value_q, value_d;
  tbhrc_pkg::mode_e            mode_q, mode_d;
  logic                        out_valid_q;

  logic                        in_txn;
  logic                        up_press, up_rel, dn_press, dn_rel;
  tbhrc_pkg::cnt_set_t         up_c, dn_c, own;
  tbhrc_pkg::cnt_t             other_hold;
  logic                        active, dir_up, step, done;
  tbhrc_pkg::phase_e           phase;
  tbhrc_pkg::mode_e            mode_slow, mode_fast, mode_other;

  // Advances the hold counter of a pressed button, and then its slow or fast
  // interval counter depending on which threshold the new hold count passes.
  function automatic tbhrc_pkg::cnt_set_t bump_hold(
    tbhrc_pkg::cnt_set_t          c,
    logic [tbhrc_pkg::THR_W-1:0]  thr_s,
    logic [tbhrc_pkg::THR_W-1:0]  thr_f
  );
    tbhrc_pkg::cnt_set_t r;
    r      = c;
    r.hold = tbhrc_pkg::sat_inc(c.hold);
    if (r.hold > tbhrc_pkg::cnt_t'(thr_f)) begin
      r.fast = tbhrc_pkg::sat_inc(c.fast);
    end else if (r.hold > tbhrc_pkg::cnt_t'(thr_s)) begin
      r.slow = tbhrc_pkg::sat_inc(c.slow);
    end
    return r;
  endfunction

  // The result register empties when its transaction is taken, which is
  // when the next tick may enter.
  assign in_ready_o      = !out_valid_q || out_ready_i;
  assign in_txn          = in_valid_i && in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign display_value_o = value_q;
  assign mode_o          = mode_q;

  // A button is stable when this sample matches the last one.
  assign up_press = (up_level_i == up_last_q) && !up_level_i;
  assign up_rel   = (up_level_i == up_last_q) &&  up_level_i;
  assign dn_press = (down_level_i == dn_last_q) && !down_level_i;
  assign dn_rel   = (down_level_i == dn_last_q) &&  down_level_i;

  always_comb begin
    // Counter update; the up button wins when both are held.
    up_c = up_cnt_q;
    dn_c = dn_cnt_q;
    if (up_press) begin
      dn_c = '0;
      up_c = bump_hold(up_cnt_q, thr_slow_q, thr_fast_q);
    end else if (dn_press) begin
      up_c = '0;
      dn_c = bump_hold(dn_cnt_q, thr_slow_q, thr_fast_q);
    end else if (up_rel || dn_rel) begin
      up_c = '0;
      dn_c = '0;
    end

    // Decode the current mode into a direction and a phase.
    active = 1'b1;
    dir_up = 1'b1;
    phase  = tbhrc_pkg::PH_FIRST;
    unique case (mode_q)
      tbhrc_pkg::MODE_UP_FIRST: phase = tbhrc_pkg::PH_FIRST;
      tbhrc_pkg::MODE_UP_SLOW:  phase = tbhrc_pkg::PH_SLOW;
      tbhrc_pkg::MODE_UP_FAST:  phase = tbhrc_pkg::PH_FAST;
      tbhrc_pkg::MODE_DN_FIRST: begin
        dir_up = 1'b0;
        phase  = tbhrc_pkg::PH_FIRST;
      end
      tbhrc_pkg::MODE_DN_SLOW: begin
        dir_up = 1'b0;
        phase  = tbhrc_pkg::PH_SLOW;
      end
      tbhrc_pkg::MODE_DN_FAST: begin
        dir_up = 1'b0;
        phase  = tbhrc_pkg::PH_FAST;
      end
      default: active = 1'b0;
    endcase

    own        = dir_up ? up_c : dn_c;
    other_hold = dir_up ? dn_c.hold : up_c.hold;
    mode_slow  = dir_up ? tbhrc_pkg::MODE_UP_SLOW  : tbhrc_pkg::MODE_DN_SLOW;
    mode_fast  = dir_up ? tbhrc_pkg::MODE_UP_FAST  : tbhrc_pkg::MODE_DN_FAST;
    mode_other = dir_up ? tbhrc_pkg::MODE_DN_FIRST : tbhrc_pkg::MODE_UP_FIRST;

    up_cnt_d = up_c;
    dn_cnt_d = dn_c;
    mode_d   = mode_q;
    step     = 1'b0;
    done     = 1'b0;

    if (active) begin
      case (phase)
        tbhrc_pkg::PH_FIRST: begin
          if (own.hold > tbhrc_pkg::cnt_t'(thr_slow_q)) begin
            mode_d = mode_slow;
            done   = 1'b1;
          end
        end
        tbhrc_pkg::PH_SLOW: begin
          if (own.slow > tbhrc_pkg::cnt_t'(slow_iv_q)) begin
            step     = 1'b1;
            own.slow = '0;
          end
          if (own.hold > tbhrc_pkg::cnt_t'(thr_fast_q)) begin
            mode_d = mode_fast;
            done   = 1'b1;
          end
        end
        default: begin
          if (own.fast > tbhrc_pkg::cnt_t'(fast_iv_q)) begin
            step     = 1'b1;
            own.fast = '0;
          end
        end
      endcase
      // Once the held button is released, the mode falls back to idle, or
      // hands over to the other button's first mode without a step.
      if (!done && (own.hold == '0)) begin
        mode_d = (other_hold != '0) ? mode_other : tbhrc_pkg::MODE_IDLE;
      end
      if (dir_up) begin
        up_cnt_d = own;
      end else begin
        dn_cnt_d = own;
      end
    end else if (up_c.hold != '0) begin
      step   = 1'b1;
      dir_up = 1'b1;
      mode_d = tbhrc_pkg::MODE_UP_FIRST;
    end else if (dn_c.hold != '0) begin
      step   = 1'b1;
      dir_up = 1'b0;
      mode_d = tbhrc_pkg::MODE_DN_FIRST;
    end else begin
      mode_d = tbhrc_pkg::MODE_IDLE;
    end

    // The value wraps modulo 256 in both directions.
    if (step) begin
      value_d = dir_up ? value_q + tbhrc_pkg::VAL_W'(1) : value_q - tbhrc_pkg::VAL_W'(1);
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_slow_q <= tbhrc_pkg::HOLD_THR_SLOW_RST;
      thr_fast_q <= tbhrc_pkg::HOLD_THR_FAST_RST;
      slow_iv_q  <= tbhrc_pkg::SLOW_IV_RST;
      fast_iv_q  <= tbhrc_pkg::FAST_IV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbhrc_pkg::REG_HOLD_THR_SLOW: thr_slow_q <= cfg_wdata_i;
        tbhrc_pkg::REG_HOLD_THR_FAST: thr_fast_q <= cfg_wdata_i;
        tbhrc_pkg::REG_SLOW_IV:       slow_iv_q  <= cfg_wdata_i[tbhrc_pkg::IV_W-1:0];
        tbhrc_pkg::REG_FAST_IV:       fast_iv_q  <= cfg_wdata_i[tbhrc_pkg::IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_last_q   <= 1'b1;
      dn_last_q   <= 1'b1;
      up_cnt_q    <= '0;
      dn_cnt_q    <= '0;
      value_q     <= '0;
      mode_q      <= tbhrc_pkg::MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_txn) begin
        up_last_q   <= up_level_i;
        dn_last_q   <= down_level_i;
        up_cnt_q    <= up_cnt_d;
        dn_cnt_q    <= dn_cnt_d;
        value_q     <= value_d;
        mode_q      <= mode_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ design/tbhrc_checker.sv @@
// Port-level checker for the two-button hold-to-repeat counter unit.
// Depends on tbhrc_pkg for widths; bound to the top level at the end of this file.
module tbhrc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [tbhrc_pkg::VAL_W-1:0]        display_value_o,
  input logic [tbhrc_pkg::MODE_W-1:0]       mode_o
);

  // An accepted tick always yields a result in the next cycle.
  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick produced no result");

  // A taken result with no new tick leaves the output empty.
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // With no result waiting the unit must take a tick.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("unit stalls input with an empty output");

  // A stalled result holds its value and mode.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(display_value_o) && $stable(mode_o))
    else $error("stalled result changed");

endmodule

bind two_button_hold_repeat_counter_unit tbhrc_checker u_tbhrc_checker (.*);
